[rtl/cqr_pkg.sv]
// shared types, constants and the saturation helper of the complex quadratic root unit
// no dependencies; used by the top level of the unit, by its checker and by the testbench
package cqr_pkg;

    // word format: signed fixed point, WordBits wide with FracBits fraction bits
    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int ProdBits = 2 * WordBits;
    localparam int WideBits = ProdBits + 2;

    // stream payload layout
    localparam int InFields    = 6;
    localparam int InDataBits  = InFields * WordBits;
    localparam int OutRoots    = 4;
    localparam int OutDataBits = OutRoots * WordBits;
    localparam int UserBits    = 2;
    localparam int UserDegen   = 0;
    localparam int UserOvf     = 1;

    // iterative stages: |delta| root, square-root parts, quotient bits
    localparam int MagIters  = WordBits;
    localparam int PartBits  = 48;
    localparam int PartIters = PartBits / 2;
    localparam int QuoBits   = WordBits + 1;
    localparam int RemShift  = QuoBits - (FracBits - 1);

    typedef logic signed [WordBits-1:0] t_word;

    localparam t_word WordMax = {1'b0, {(WordBits-1){1'b1}}};
    localparam t_word WordMin = {1'b1, {(WordBits-1){1'b0}}};

    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_sat;

    // clamp a wide signed value to the word range and flag the clamp
    function automatic t_sat sat_word(input logic signed [WideBits-1:0] x);
        t_sat s;
        s.ovf = 1'b0;
        s.val = x[WordBits-1:0];
        if (x > WideBits'(WordMax)) begin
            s.ovf = 1'b1;
            s.val = WordMax;
        end else if (x < WideBits'(WordMin)) begin
            s.ovf = 1'b1;
            s.val = WordMin;
        end
        return s;
    endfunction

endpackage

[rtl/complex_quadratic_roots_unit.sv]
// top level of the complex quadratic root unit: front-end arithmetic, three cell rows
// depends on cqr_pkg, cqr_sqrt_chain, cqr_div_chain
//
//  channel  | dir | tdata (low to high)                         | tuser
//  s_axis   | in  | a_re, a_im, b_re, b_im, c_re, c_im (32 each) | -
//  m_axis   | out | first_re, first_im, second_re, second_im     | degenerate, overflowed
//
// one transaction per cycle on both sides while m_axis is not stalled; the rows of
// cells hold 32 stages for |delta|, 24 for the square-root parts and 33 for the quotients,
// plus 12 registered arithmetic stages around them
// reset is synchronous, active low, and empties the pipeline
// a stall on m_axis freezes every stage; s_axis_tready falls in the same cycle
module complex_quadratic_roots_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // coef_a_re, coef_a_im, coef_b_re, coef_b_im, coef_c_re, coef_c_im
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // first_root_re, first_root_im, second_root_re, second_root_im
    output logic [1:0]   m_axis_tuser    // degenerate, overflowed
);

    localparam int W  = cqr_pkg::WordBits;
    localparam int P  = cqr_pkg::ProdBits;
    localparam int F  = cqr_pkg::FracBits;
    localparam int WB = cqr_pkg::WideBits;
    localparam int PB = cqr_pkg::PartBits;
    localparam int PI = cqr_pkg::PartIters;
    localparam int QW = cqr_pkg::QuoBits;
    localparam int RS = cqr_pkg::RemShift;
    localparam int SideA = 6 * W + P + 2;
    localparam int SideB = 4 * W + P + 3;
    localparam int SideC = 10;

    logic w_en;

    // stage 0: input register
    logic r0_valid;
    cqr_pkg::t_word r0_ar, r0_ai, r0_br, r0_bi, r0_cr, r0_ci;
    // stage 1: products
    logic r1_valid, r1_degen;
    cqr_pkg::t_word r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [P-1:0] r1_pbb_rr, r1_pbb_ii, r1_pbb_ri;
    logic signed [P-1:0] r1_pac_rr, r1_pac_ii, r1_pac_ri, r1_pac_ir;
    logic signed [P-1:0] r1_paa_r, r1_paa_i;
    // stage 2: b*b and a*c
    logic r2_valid, r2_degen, r2_ovf;
    cqr_pkg::t_word r2_ar, r2_ai, r2_br, r2_bi, r2_bbr, r2_bbi, r2_acr, r2_aci;
    logic [P-1:0] r2_den;
    cqr_pkg::t_sat s_bbr, s_bbi, s_acr, s_aci;
    // stage 3: 4ac
    logic r3_valid, r3_degen, r3_ovf;
    cqr_pkg::t_word r3_ar, r3_ai, r3_br, r3_bi, r3_bbr, r3_bbi, r3_acr, r3_aci;
    logic [P-1:0] r3_den;
    cqr_pkg::t_sat s_acr4, s_aci4;
    // stage 4: delta
    logic r4_valid, r4_degen, r4_ovf;
    cqr_pkg::t_word r4_ar, r4_ai, r4_br, r4_bi, r4_dr, r4_di;
    logic [P-1:0] r4_den;
    cqr_pkg::t_sat s_dr, s_di;
    // stage 5: squares of delta
    logic r5_valid, r5_degen, r5_ovf;
    cqr_pkg::t_word r5_ar, r5_ai, r5_br, r5_bi, r5_dr, r5_di;
    logic [P-1:0] r5_den;
    logic signed [P-1:0] r5_pdr, r5_pdi;
    // stage 6: |delta|^2
    logic r6_valid, r6_degen, r6_ovf;
    cqr_pkg::t_word r6_ar, r6_ai, r6_br, r6_bi, r6_dr, r6_di;
    logic [P-1:0] r6_den, r6_mag2;
    // row A output
    logic a_valid, a_degen, a_ovf;
    logic [W-1:0] a_absd;
    cqr_pkg::t_word a_ar, a_ai, a_br, a_bi, a_dr, a_di;
    logic [P-1:0] a_den;
    logic [SideA-1:0] w_a_side_in, w_a_side_out;
    // stage 7: square-root radicands
    logic r7_valid, r7_degen, r7_ovf, r7_dineg;
    cqr_pkg::t_word r7_ar, r7_ai, r7_br, r7_bi;
    logic [P-1:0] r7_den;
    logic [1:0][PB-1:0] r7_rad;
    logic [W+1:0] w_sum_p, w_sum_m;
    // row B output
    logic b_valid, b_degen, b_ovf, b_dineg;
    cqr_pkg::t_word b_ar, b_ai, b_br, b_bi;
    logic [P-1:0] b_den;
    logic [1:0][PI-1:0] b_root;
    logic [SideB-1:0] w_b_side_in, w_b_side_out;
    // stage 8: numerators -b +/- s
    logic r8_valid, r8_degen, r8_ovf;
    cqr_pkg::t_word r8_ar, r8_ai;
    cqr_pkg::t_word r8_n [4];
    logic [P-1:0] r8_den;
    logic signed [WB-1:0] w_sr, w_si;
    cqr_pkg::t_sat s_n [4];
    // stage 9: numerator times conj(a)
    logic r9_valid, r9_degen, r9_ovf;
    logic signed [P-1:0] r9_pa [2];
    logic signed [P-1:0] r9_pb [2];
    logic signed [P-1:0] r9_pc [2];
    logic signed [P-1:0] r9_pd [2];
    logic [P-1:0] r9_den;
    // stage 10: magnitude and sign of each part
    logic r10_valid, r10_degen, r10_ovf;
    logic [P-1:0] r10_mag [4];
    logic [3:0] r10_neg;
    logic [P-1:0] r10_den;
    logic signed [P:0] w_num [4];
    // row C
    logic [3:0][P-1:0] w_c_rem;
    logic [3:0][QW-1:0] w_c_quo;
    logic [3:0] w_big;
    logic [SideC-1:0] w_c_side_in, w_c_side_out;
    logic c_valid, c_degen, c_ovf;
    logic [3:0] c_neg, c_big;
    logic [3:0][QW-1:0] c_quo;
    // output stage
    cqr_pkg::t_sat s_q [4];
    logic w_q_ovf;
    logic r_out_valid, r_out_degen, r_out_ovf;
    cqr_pkg::t_word r_first_re, r_first_im, r_second_re, r_second_im;
    cqr_pkg::t_word n_first_re, n_first_im, n_second_re, n_second_im;

    // the whole pipeline moves when the output register can take a result
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // valid flags of the registered stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r10_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid    <= s_axis_tvalid;
            r1_valid    <= r0_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= a_valid;
            r8_valid    <= b_valid;
            r9_valid    <= r8_valid;
            r10_valid   <= r9_valid;
            r_out_valid <= c_valid;
        end
    end

    // stages 0 and 1: capture coefficients, form the products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_ar <= s_axis_tdata[0*W +: W];
            r0_ai <= s_axis_tdata[1*W +: W];
            r0_br <= s_axis_tdata[2*W +: W];
            r0_bi <= s_axis_tdata[3*W +: W];
            r0_cr <= s_axis_tdata[4*W +: W];
            r0_ci <= s_axis_tdata[5*W +: W];

            r1_degen  <= (r0_ar == '0) && (r0_ai == '0);
            r1_ar     <= r0_ar;
            r1_ai     <= r0_ai;
            r1_br     <= r0_br;
            r1_bi     <= r0_bi;
            r1_pbb_rr <= r0_br * r0_br;
            r1_pbb_ii <= r0_bi * r0_bi;
            r1_pbb_ri <= r0_br * r0_bi;
            r1_pac_rr <= r0_ar * r0_cr;
            r1_pac_ii <= r0_ai * r0_ci;
            r1_pac_ri <= r0_ar * r0_ci;
            r1_pac_ir <= r0_ai * r0_cr;
            r1_paa_r  <= r0_ar * r0_ar;
            r1_paa_i  <= r0_ai * r0_ai;
        end
    end

    // stage 2: rescale products (floor), b*b and a*c, |a|^2
    always_comb begin
        s_bbr = cqr_pkg::sat_word(WB'(r1_pbb_rr >>> F) - WB'(r1_pbb_ii >>> F));
        s_bbi = cqr_pkg::sat_word(WB'(r1_pbb_ri >>> F) <<< 1);
        s_acr = cqr_pkg::sat_word(WB'(r1_pac_rr >>> F) - WB'(r1_pac_ii >>> F));
        s_aci = cqr_pkg::sat_word(WB'(r1_pac_ri >>> F) + WB'(r1_pac_ir >>> F));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_degen <= r1_degen;
            r2_ar    <= r1_ar;
            r2_ai    <= r1_ai;
            r2_br    <= r1_br;
            r2_bi    <= r1_bi;
            r2_bbr   <= s_bbr.val;
            r2_bbi   <= s_bbi.val;
            r2_acr   <= s_acr.val;
            r2_aci   <= s_aci.val;
            r2_den   <= $unsigned(r1_paa_r) + $unsigned(r1_paa_i);
            r2_ovf   <= s_bbr.ovf | s_bbi.ovf | s_acr.ovf | s_aci.ovf;
        end
    end

    // stage 3: times four
    always_comb begin
        s_acr4 = cqr_pkg::sat_word(WB'(r2_acr) <<< 2);
        s_aci4 = cqr_pkg::sat_word(WB'(r2_aci) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_degen <= r2_degen;
            r3_ar    <= r2_ar;
            r3_ai    <= r2_ai;
            r3_br    <= r2_br;
            r3_bi    <= r2_bi;
            r3_bbr   <= r2_bbr;
            r3_bbi   <= r2_bbi;
            r3_acr   <= s_acr4.val;
            r3_aci   <= s_aci4.val;
            r3_den   <= r2_den;
            r3_ovf   <= r2_ovf | s_acr4.ovf | s_aci4.ovf;
        end
    end

    // stage 4: delta = b*b - 4ac
    always_comb begin
        s_dr = cqr_pkg::sat_word(WB'(r3_bbr) - WB'(r3_acr));
        s_di = cqr_pkg::sat_word(WB'(r3_bbi) - WB'(r3_aci));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_degen <= r3_degen;
            r4_ar    <= r3_ar;
            r4_ai    <= r3_ai;
            r4_br    <= r3_br;
            r4_bi    <= r3_bi;
            r4_dr    <= s_dr.val;
            r4_di    <= s_di.val;
            r4_den   <= r3_den;
            r4_ovf   <= r3_ovf | s_dr.ovf | s_di.ovf;
        end
    end

    // stages 5 and 6: squared magnitude of delta
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_degen <= r4_degen;
            r5_ar    <= r4_ar;
            r5_ai    <= r4_ai;
            r5_br    <= r4_br;
            r5_bi    <= r4_bi;
            r5_dr    <= r4_dr;
            r5_di    <= r4_di;
            r5_den   <= r4_den;
            r5_ovf   <= r4_ovf;
            r5_pdr   <= r4_dr * r4_dr;
            r5_pdi   <= r4_di * r4_di;

            r6_degen <= r5_degen;
            r6_ar    <= r5_ar;
            r6_ai    <= r5_ai;
            r6_br    <= r5_br;
            r6_bi    <= r5_bi;
            r6_dr    <= r5_dr;
            r6_di    <= r5_di;
            r6_den   <= r5_den;
            r6_ovf   <= r5_ovf;
            r6_mag2  <= $unsigned(r5_pdr) + $unsigned(r5_pdi);
        end
    end

    // row A: |delta| = floor(sqrt(re^2 + im^2))
    assign w_a_side_in = {r6_ar, r6_ai, r6_br, r6_bi, r6_dr, r6_di, r6_den, r6_ovf, r6_degen};

    cqr_sqrt_chain #(
        .NW    (P),
        .ITERS (cqr_pkg::MagIters),
        .LANES (1),
        .SW    (SideA)
    ) u_mag_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_valid),
        .i_rad   (r6_mag2),
        .i_side  (w_a_side_in),
        .o_valid (a_valid),
        .o_root  (a_absd),
        .o_side  (w_a_side_out)
    );

    assign {a_ar, a_ai, a_br, a_bi, a_dr, a_di, a_den, a_ovf, a_degen} = w_a_side_out;

    // stage 7: (|delta| +/- re) scaled by half a unit
    always_comb begin
        w_sum_p = {2'b00, a_absd} + {{2{a_dr[W-1]}}, a_dr};
        w_sum_m = {2'b00, a_absd} - {{2{a_dr[W-1]}}, a_dr};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_degen  <= a_degen;
            r7_ar     <= a_ar;
            r7_ai     <= a_ai;
            r7_br     <= a_br;
            r7_bi     <= a_bi;
            r7_den    <= a_den;
            r7_ovf    <= a_ovf;
            r7_dineg  <= a_di[W-1];
            r7_rad[0] <= PB'({w_sum_p, {(F-1){1'b0}}});
            r7_rad[1] <= PB'({w_sum_m, {(F-1){1'b0}}});
        end
    end

    // row B: real and imaginary parts of the principal square root
    assign w_b_side_in = {r7_ar, r7_ai, r7_br, r7_bi, r7_den, r7_ovf, r7_dineg, r7_degen};

    cqr_sqrt_chain #(
        .NW    (PB),
        .ITERS (PI),
        .LANES (2),
        .SW    (SideB)
    ) u_part_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_valid),
        .i_rad   (r7_rad),
        .i_side  (w_b_side_in),
        .o_valid (b_valid),
        .o_root  (b_root),
        .o_side  (w_b_side_out)
    );

    assign {b_ar, b_ai, b_br, b_bi, b_den, b_ovf, b_dineg, b_degen} = w_b_side_out;

    // stage 8: numerators -b + s and -b - s; imaginary root part takes delta's sign
    always_comb begin
        w_sr = $signed({{(WB-PI){1'b0}}, b_root[0]});
        w_si = b_dineg ? -$signed({{(WB-PI){1'b0}}, b_root[1]})
                       : $signed({{(WB-PI){1'b0}}, b_root[1]});
        s_n[0] = cqr_pkg::sat_word(w_sr - WB'(b_br));
        s_n[1] = cqr_pkg::sat_word(w_si - WB'(b_bi));
        s_n[2] = cqr_pkg::sat_word(-WB'(b_br) - w_sr);
        s_n[3] = cqr_pkg::sat_word(-WB'(b_bi) - w_si);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_degen <= b_degen;
            r8_ar    <= b_ar;
            r8_ai    <= b_ai;
            r8_den   <= b_den;
            r8_ovf   <= b_ovf | s_n[0].ovf | s_n[1].ovf | s_n[2].ovf | s_n[3].ovf;
            for (int k = 0; k < 4; k++) begin
                r8_n[k] <= s_n[k].val;
            end
        end
    end

    // stage 9: numerator times conj(a), both roots
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_degen <= r8_degen;
            r9_den   <= r8_den;
            r9_ovf   <= r8_ovf;
            for (int j = 0; j < 2; j++) begin
                r9_pa[j] <= r8_n[2*j]   * r8_ar;
                r9_pb[j] <= r8_n[2*j+1] * r8_ai;
                r9_pc[j] <= r8_n[2*j+1] * r8_ar;
                r9_pd[j] <= r8_n[2*j]   * r8_ai;
            end
        end
    end

    // stage 10: sign and magnitude of each quotient numerator
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_num[2*j]   = (P+1)'(r9_pa[j]) + (P+1)'(r9_pb[j]);
            w_num[2*j+1] = (P+1)'(r9_pc[j]) - (P+1)'(r9_pd[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_degen <= r9_degen;
            r10_den   <= r9_den;
            r10_ovf   <= r9_ovf;
            for (int k = 0; k < 4; k++) begin
                r10_neg[k] <= w_num[k][P];
                r10_mag[k] <= w_num[k][P] ? P'(-w_num[k]) : w_num[k][P-1:0];
            end
        end
    end

    // row C: floor(mag * 2^(F-1) / |a|^2), quotients at or above 2^QW flagged as big
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_c_rem[k] = r10_mag[k] >> RS;
            w_c_quo[k] = {r10_mag[k][RS-1:0], {(F-1){1'b0}}};
            w_big[k]   = (r10_mag[k] >> RS) >= r10_den;
        end
    end

    assign w_c_side_in = {r10_neg, w_big, r10_ovf, r10_degen};

    cqr_div_chain #(
        .RW    (P),
        .QW    (QW),
        .LANES (4),
        .SW    (SideC)
    ) u_quo_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r10_valid),
        .i_rem   (w_c_rem),
        .i_quo   (w_c_quo),
        .i_den   (r10_den),
        .i_side  (w_c_side_in),
        .o_valid (c_valid),
        .o_quo   (c_quo),
        .o_side  (w_c_side_out)
    );

    assign {c_neg, c_big, c_ovf, c_degen} = w_c_side_out;

    // output stage: apply sign, clamp, order the roots
    always_comb begin
        w_q_ovf = 1'b0;
        for (int k = 0; k < 4; k++) begin
            s_q[k] = cqr_pkg::sat_word(c_neg[k] ? -$signed({{(WB-QW){1'b0}}, c_quo[k]})
                                                : $signed({{(WB-QW){1'b0}}, c_quo[k]}));
            if (c_big[k]) begin
                s_q[k].ovf = 1'b1;
                s_q[k].val = c_neg[k] ? cqr_pkg::WordMin : cqr_pkg::WordMax;
            end
            w_q_ovf = w_q_ovf | s_q[k].ovf;
        end
        if ($signed(s_q[1].val) > 0) begin
            n_first_re  = s_q[0].val;
            n_first_im  = s_q[1].val;
            n_second_re = s_q[2].val;
            n_second_im = s_q[3].val;
        end else begin
            n_first_re  = s_q[2].val;
            n_first_im  = s_q[3].val;
            n_second_re = s_q[0].val;
            n_second_im = s_q[1].val;
        end
        if (c_degen) begin
            n_first_re  = '0;
            n_first_im  = '0;
            n_second_re = '0;
            n_second_im = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_degen <= c_degen;
            r_out_ovf   <= !c_degen && (c_ovf || w_q_ovf);
            r_first_re  <= n_first_re;
            r_first_im  <= n_first_im;
            r_second_re <= n_second_re;
            r_second_im <= n_second_im;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_second_im, r_second_re, r_first_im, r_first_re};
    assign m_axis_tuser  = {r_out_ovf, r_out_degen};

endmodule

[rtl/cqr_sqrt_cell.sv]
// one step of the digit-by-digit integer square root, with its own stage register
// no package dependency; instantiated in rows by cqr_sqrt_chain
module cqr_sqrt_cell #(
    parameter int NW    = 64,
    parameter int SHIFT = 62
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem,
    input  logic [NW-1:0] i_res,
    output logic [NW-1:0] o_rem,
    output logic [NW-1:0] o_res
);

    localparam logic [NW:0] Bit = (NW+1)'(1) << SHIFT;

    logic [NW:0]   w_trial;
    logic          w_take;
    logic [NW-1:0] n_rem;
    logic [NW-1:0] n_res;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_res;

    // try to subtract the current candidate from the remainder
    always_comb begin
        w_trial = {1'b0, i_res} + Bit;
        w_take  = {1'b0, i_rem} >= w_trial;
        if (w_take) begin
            n_rem = i_rem - w_trial[NW-1:0];
            n_res = (i_res >> 1) + Bit[NW-1:0];
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;

endmodule

[rtl/cqr_sqrt_chain.sv]
// row of square-root cells, one result bit per stage, lanes side by side
// depends on cqr_sqrt_cell
module cqr_sqrt_chain #(
    parameter int NW    = 64,
    parameter int ITERS = 32,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NW-1:0]     i_rad,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][ITERS-1:0]  o_root,
    output logic [SW-1:0]                o_side
);

    logic [NW-1:0] w_rem [ITERS+1][LANES];
    logic [NW-1:0] w_res [ITERS+1][LANES];
    logic [ITERS-1:0] r_valid;
    logic [SW-1:0]    r_side [ITERS];

    // cells: stage k handles result bit ITERS-1-k
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_rem[0][l] = i_rad[l];
        assign w_res[0][l] = '0;
        for (genvar k = 0; k < ITERS; k++) begin : g_cell
            cqr_sqrt_cell #(
                .NW    (NW),
                .SHIFT (2 * (ITERS - 1 - k))
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rem (w_rem[k][l]),
                .i_res (w_res[k][l]),
                .o_rem (w_rem[k+1][l]),
                .o_res (w_res[k+1][l])
            );
        end
        assign o_root[l] = w_res[ITERS][l][ITERS-1:0];
    end

    // valid flags follow the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[ITERS-2:0], i_valid};
        end
    end

    // sideband travels with the item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < ITERS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[ITERS-1];
    assign o_side  = r_side[ITERS-1];

endmodule

[rtl/cqr_div_cell.sv]
// one step of restoring division, with its own stage register
// no package dependency; instantiated in rows by cqr_div_chain
module cqr_div_cell #(
    parameter int RW = 64,
    parameter int QW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_quo,
    input  logic [RW-1:0] i_den,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_quo
);

    logic [RW:0]   w_part;
    logic          w_take;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quo;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_part = {i_rem, i_quo[QW-1]};
        w_take = w_part >= {1'b0, i_den};
        if (w_take) begin
            n_rem = RW'(w_part - {1'b0, i_den});
        end else begin
            n_rem = w_part[RW-1:0];
        end
        n_quo = {i_quo[QW-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

[rtl/cqr_div_chain.sv]
// row of division cells sharing one divisor, one quotient bit per stage
// depends on cqr_div_cell
module cqr_div_chain #(
    parameter int RW    = 64,
    parameter int QW    = 33,
    parameter int LANES = 4,
    parameter int SW    = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [LANES-1:0][RW-1:0]  i_rem,
    input  logic [LANES-1:0][QW-1:0]  i_quo,
    input  logic [RW-1:0]             i_den,
    input  logic [SW-1:0]             i_side,
    output logic                      o_valid,
    output logic [LANES-1:0][QW-1:0]  o_quo,
    output logic [SW-1:0]             o_side
);

    logic [RW-1:0] w_rem [QW+1][LANES];
    logic [QW-1:0] w_quo [QW+1][LANES];
    logic [RW-1:0] w_den [QW];
    logic [QW-1:0] r_valid;
    logic [SW-1:0] r_side [QW];
    logic [RW-1:0] r_den  [QW-1];

    // divisor seen by each stage
    assign w_den[0] = i_den;
    for (genvar k = 1; k < QW; k++) begin : g_den
        assign w_den[k] = r_den[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_rem[0][l] = i_rem[l];
        assign w_quo[0][l] = i_quo[l];
        for (genvar k = 0; k < QW; k++) begin : g_cell
            cqr_div_cell #(
                .RW (RW),
                .QW (QW)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rem (w_rem[k][l]),
                .i_quo (w_quo[k][l]),
                .i_den (w_den[k]),
                .o_rem (w_rem[k+1][l]),
                .o_quo (w_quo[k+1][l])
            );
        end
        assign o_quo[l] = w_quo[QW][l];
    end

    // valid flags follow the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QW-2:0], i_valid};
        end
    end

    // divisor and sideband travel with the item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 1; k < QW - 1; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[rtl/cqr_checker.sv]
// port-level checks of the complex quadratic root unit, bound to the top level
// depends on cqr_pkg and complex_quadratic_roots_unit
module cqr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    localparam int W = cqr_pkg::WordBits;

    // input side opens exactly when the output register can move
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("s_axis_tready does not follow the output stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // degenerate transaction carries zero roots and no overflow
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[cqr_pkg::UserDegen] |->
            (m_axis_tdata == '0) && !m_axis_tuser[cqr_pkg::UserOvf])
        else $error("degenerate transaction with nonzero roots or overflow");

    // root with positive imaginary part leads: a non-positive first leaves a non-positive second
    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[cqr_pkg::UserDegen] &&
            !($signed(m_axis_tdata[2*W-1:W]) > 0) |->
            !($signed(m_axis_tdata[4*W-1:3*W]) > 0))
        else $error("roots listed in the wrong order");

endmodule

bind complex_quadratic_roots_unit cqr_checker u_cqr_checker (.*);

[dv/complex_quadratic_roots_unit_test.sv]
// self-checking testbench of the complex quadratic root unit: coefficient sets in, roots out
// depends on cqr_pkg and complex_quadratic_roots_unit; a scoreboard class predicts every root pair
`timescale 1ns / 100ps

module complex_quadratic_roots_unit_test;

    localparam int     CycleLimit = 400000;
    localparam int     DrainWait  = 150;
    localparam int     HoldCycles = 500;
    localparam longint QuotCap    = 64'd1 << 40;

    typedef cqr_pkg::t_word t_coefs [6];   // a_re, a_im, b_re, b_im, c_re, c_im

    typedef struct {
        cqr_pkg::t_word roots [4];      // first_re, first_im, second_re, second_im
        bit             degen;
        bit             ovf;
    } t_roots;

    // root predictor and in-order store of expected root pairs
    class root_scoreboard;
        t_roots pending_roots [$];
        int     errors;
        int     checked;
        int     degen_seen;
        int     ovf_seen;
        bit     sat_flag;

        function longint clamp(longint x);
            if (x > longint'(cqr_pkg::WordMax)) begin
                sat_flag = 1'b1;
                return longint'(cqr_pkg::WordMax);
            end
            if (x < longint'(cqr_pkg::WordMin)) begin
                sat_flag = 1'b1;
                return longint'(cqr_pkg::WordMin);
            end
            return x;
        endfunction

        // fixed-point product, floored
        function longint qmul(longint x, longint y);
            return (x * y) >>> cqr_pkg::FracBits;
        endfunction

        function bit [63:0] floor_sqrt(bit [63:0] n);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // magnitude and sign of p1 + p2 without 64-bit wrap
        function bit [63:0] sum_mag(longint p1, longint p2, output bit neg);
            longint s;
            if (p1 >= 0 && p2 >= 0) begin
                neg = 1'b0;
                return 64'(p1) + 64'(p2);
            end
            if (p1 < 0 && p2 < 0) begin
                neg = 1'b1;
                return 64'(-p1) + 64'(-p2);
            end
            s   = p1 + p2;
            neg = s < 0;
            return neg ? 64'(-s) : 64'(s);
        endfunction

        // trunc(mag * 2^(frac-1) / den), capped
        function longint scaled_quot(bit [63:0] mag, bit [63:0] den, bit neg);
            bit [127:0] q;
            longint     m;
            q = ({64'd0, mag} << (cqr_pkg::FracBits - 1)) / {64'd0, den};
            m = (q > 128'(QuotCap)) ? QuotCap : longint'(q[63:0]);
            return clamp(neg ? -m : m);
        endfunction

        function t_roots predict(t_coefs k);
            t_roots    r;
            longint    ar, ai, br, bi, cr, ci;
            longint    bbr, bbi, acr, aci, dr, di, absd, sr, si;
            longint    nr [2];
            longint    ni [2];
            longint    qr [2];
            longint    qi [2];
            bit [63:0] den;
            bit        neg;
            sat_flag = 1'b0;
            ar = k[0]; ai = k[1]; br = k[2]; bi = k[3]; cr = k[4]; ci = k[5];
            r.degen = 1'b0;
            if (ar == 0 && ai == 0) begin
                foreach (r.roots[j]) r.roots[j] = '0;
                r.degen = 1'b1;
                r.ovf   = 1'b0;
                return r;
            end
            // discriminant
            bbr = clamp(qmul(br, br) - qmul(bi, bi));
            bbi = clamp(qmul(br, bi) + qmul(bi, br));
            acr = clamp(qmul(ar, cr) - qmul(ai, ci));
            aci = clamp(qmul(ar, ci) + qmul(ai, cr));
            acr = clamp(acr * 4);
            aci = clamp(aci * 4);
            dr  = clamp(bbr - acr);
            di  = clamp(bbi - aci);
            // principal square root
            absd = longint'(floor_sqrt(64'(dr * dr) + 64'(di * di)));
            sr   = clamp(longint'(floor_sqrt(64'(absd + dr) << (cqr_pkg::FracBits - 1))));
            si   = longint'(floor_sqrt(64'(absd - dr) << (cqr_pkg::FracBits - 1)));
            si   = clamp(di < 0 ? -si : si);
            // both roots via n * conj(a) / (2 |a|^2)
            den   = 64'(ar * ar) + 64'(ai * ai);
            nr[0] = clamp(-br + sr);
            ni[0] = clamp(-bi + si);
            nr[1] = clamp(-br - sr);
            ni[1] = clamp(-bi - si);
            for (int j = 0; j < 2; j++) begin
                bit [63:0] m;
                m     = sum_mag(nr[j] * ar, ni[j] * ai, neg);
                qr[j] = scaled_quot(m, den, neg);
                m     = sum_mag(ni[j] * ar, -(nr[j] * ai), neg);
                qi[j] = scaled_quot(m, den, neg);
            end
            // root with positive imaginary part goes first
            if (qi[0] > 0) begin
                r.roots[0] = cqr_pkg::t_word'(qr[0]); r.roots[1] = cqr_pkg::t_word'(qi[0]);
                r.roots[2] = cqr_pkg::t_word'(qr[1]); r.roots[3] = cqr_pkg::t_word'(qi[1]);
            end else begin
                r.roots[0] = cqr_pkg::t_word'(qr[1]); r.roots[1] = cqr_pkg::t_word'(qi[1]);
                r.roots[2] = cqr_pkg::t_word'(qr[0]); r.roots[3] = cqr_pkg::t_word'(qi[0]);
            end
            r.ovf = sat_flag;
            return r;
        endfunction

        function void note_coefs(t_coefs k);
            pending_roots.push_back(predict(k));
        endfunction

        function void check_roots(logic [cqr_pkg::OutDataBits-1:0] data,
                                  logic [cqr_pkg::UserBits-1:0] user);
            t_roots         exp_r;
            cqr_pkg::t_word got;
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result tdata %h tuser %b", $time, data, user);
                errors++;
                return;
            end
            exp_r = pending_roots.pop_front();
            checked++;
            if (exp_r.degen) degen_seen++;
            if (exp_r.ovf) ovf_seen++;
            for (int j = 0; j < cqr_pkg::OutRoots; j++) begin
                got = data[j*cqr_pkg::WordBits +: cqr_pkg::WordBits];
                if (got !== exp_r.roots[j]) begin
                    $display("%0t: root field %0d expected %h actual %h",
                             $time, j, exp_r.roots[j], got);
                    errors++;
                end
            end
            if (user[cqr_pkg::UserDegen] !== exp_r.degen) begin
                $display("%0t: degenerate expected %b actual %b",
                         $time, exp_r.degen, user[cqr_pkg::UserDegen]);
                errors++;
            end
            if (user[cqr_pkg::UserOvf] !== exp_r.ovf) begin
                $display("%0t: overflowed expected %b actual %b",
                         $time, exp_r.ovf, user[cqr_pkg::UserOvf]);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cqr_pkg::InDataBits-1:0]  s_axis_tdata;   // a_re, a_im, b_re, b_im, c_re, c_im
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cqr_pkg::OutDataBits-1:0] m_axis_tdata;   // first_re, first_im, second_re, second_im
    logic [cqr_pkg::UserBits-1:0]    m_axis_tuser;   // degenerate, overflowed

    root_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_seq;
    int             cycles = 0;
    int             sent;

    complex_quadratic_roots_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check transactions, stall at random, long hold on request
    initial begin : result_side
        int seen_seq;
        int hold_left;
        seen_seq  = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (m_axis_tvalid && m_axis_tready)
                    sb.check_roots(m_axis_tdata, m_axis_tuser);
                if (hold_seq != seen_seq) begin
                    seen_seq  = hold_seq;
                    hold_left = HoldCycles;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
                end
            end
        end
    end

    // offer one coefficient set, idling first at random
    task automatic send_coefs(t_coefs k);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {k[5], k[4], k[3], k[2], k[1], k[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_coefs(k);
        sent++;
    endtask

    function automatic cqr_pkg::t_word rand_word(int mode);
        case (mode)
            0: return cqr_pkg::t_word'($urandom);
            1: return cqr_pkg::t_word'(int'($urandom_range(32'h000FFFFF)) - 32'sh0007FFFF);
            default: return cqr_pkg::t_word'(int'($urandom_range(32'h0009FFFF)) - 32'sh0004FFFF);
        endcase
    endfunction

    task automatic send_random(int count);
        t_coefs k;
        int     mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(9);
            mode = (mode < 2) ? 0 : (mode < 6) ? 1 : 2;
            foreach (k[j]) k[j] = rand_word(($urandom_range(7) == 0) ? 0 : mode);
            if ($urandom_range(15) == 0) begin
                k[0] = '0;
                k[1] = '0;
            end else if ($urandom_range(9) == 0) begin
                k[$urandom_range(1)] = '0;
            end
            send_coefs(k);
        end
    endtask

    localparam cqr_pkg::t_word One  = 32'sh0001_0000;
    localparam cqr_pkg::t_word MOne = -32'sh0001_0000;
    localparam cqr_pkg::t_word Two  = 32'sh0002_0000;
    localparam cqr_pkg::t_word Lsb  = 32'sh0000_0001;
    localparam cqr_pkg::t_word WMax = cqr_pkg::WordMax;
    localparam cqr_pkg::t_word WMin = cqr_pkg::WordMin;

    initial begin : stimulus
        t_coefs dir [$];
        sb            = new();
        sent          = 0;
        hold_seq      = 0;
        send_idle_pct = 23;
        recv_idle_pct = 86;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets: degenerate, real and imaginary discriminants, extremes
        dir.push_back('{'0, '0, '0, '0, '0, '0});
        dir.push_back('{'0, '0, One, MOne, Two, One});
        dir.push_back('{One, '0, '0, '0, MOne, '0});
        dir.push_back('{One, '0, '0, '0, One, '0});
        dir.push_back('{One, '0, Two, '0, One, '0});
        dir.push_back('{'0, One, One, '0, One, '0});
        dir.push_back('{'0, MOne, '0, One, '0, Two});
        dir.push_back('{One, '0, '0, '0, '0, One});
        dir.push_back('{One, '0, One, MOne, '0, MOne});
        dir.push_back('{WMax, WMax, WMax, WMax, WMax, WMax});
        dir.push_back('{WMin, WMin, WMin, WMin, WMin, WMin});
        dir.push_back('{WMin, WMax, WMax, WMin, WMax, WMin});
        dir.push_back('{Lsb, '0, WMax, '0, '0, '0});
        dir.push_back('{WMax, '0, Lsb, '0, WMin, '0});
        dir.push_back('{Lsb, Lsb, WMin, WMax, Lsb, '0});
        dir.push_back('{32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                        32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA});
        dir.push_back('{32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                        32'sh55555555, 32'shAAAAAAAA, 32'sh55555555});
        dir.push_back('{-Lsb, '0, '0, -Lsb, '0, '0});
        dir.push_back('{Two, '0, '0, '0, '0, '0});
        dir.push_back('{One, One, '0, Two, -Two, '0});
        foreach (dir[n]) send_coefs(dir[n]);

        send_random(500);
        send_idle_pct = 86;
        recv_idle_pct = 23;
        send_random(500);
        // no idling; result side holds off so the pipeline backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq      = 1;
        send_random(530);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_roots.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("%0d coefficient sets sent, %0d root pairs checked", sent, sb.checked);
        $display("%0d degenerate, %0d saturated", sb.degen_seen, sb.ovf_seen);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
